>>> rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants of the circular FIFO with clear and dump.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIELD_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_DUMP  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_POPPED  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CLEARED = 3'd4,
    ST_DUMPED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] customer_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  entry_id;
    logic                last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    store;       // write the item's identifier at the tail
    logic    clear;       // reset pointers and count
    logic    rd_en;       // issue a store read
    logic    rd_dump;     // read address: 0 head, 1 dump pointer
    logic    dump_init;   // start a dump walk at the head
    logic    dump_adv;    // step the dump walk
    logic    pop_adv;     // retire the head entry
    logic    out_load;    // load the result register
    status_e out_status;
    logic    out_use_rd;  // result identifier comes from the store read
    logic    out_last;
  } cfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
  } cfq_stat_t;

endpackage

>>> rtl/cfq_ram.sv
// ----------------------------------------------------------------------------
// cfq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cfq_datapath.sv
// ----------------------------------------------------------------------------
// cfq_datapath
// Entry store, head and tail pointers, occupancy count, dump walk and the
// result register.
// ----------------------------------------------------------------------------
module cfq_datapath
  import cfq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cfq_cmd_t  cmd_i,
  output cfq_stat_t stat_o,
  output out_item_t out_item_o
);

  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   dump_ptr_q, dump_ptr_d;
  logic [CNT_W-1:0]   dump_left_q, dump_left_d;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data;
  out_item_t          out_q;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  assign rd_addr = cmd_i.rd_dump ? dump_ptr_q : head_q;

  cfq_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(tail_q),
    .wdata_i(ID_BITS'(in_item_i.customer_id)),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    dump_ptr_d  = dump_ptr_q;
    dump_left_d = dump_left_q;
    if (cmd_i.clear) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end else if (cmd_i.store) begin
      tail_d = next_idx(tail_q);
      occ_d  = occ_q + CNT_W'(1);
    end else if (cmd_i.pop_adv) begin
      head_d = next_idx(head_q);
      occ_d  = occ_q - CNT_W'(1);
    end
    // The first dump read goes to the head, so the walk continues one past it.
    if (cmd_i.dump_init) begin
      dump_ptr_d  = next_idx(head_q);
      dump_left_d = occ_q;
    end else if (cmd_i.dump_adv) begin
      dump_ptr_d  = next_idx(dump_ptr_q);
      dump_left_d = dump_left_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      dump_ptr_q  <= '0;
      dump_left_q <= '0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      dump_ptr_q  <= dump_ptr_d;
      dump_left_q <= dump_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status   <= cmd_i.out_status;
      out_q.entry_id <= cmd_i.out_use_rd ? FIELD_W'(rd_data) : '0;
      out_q.last     <= cmd_i.out_last;
    end
  end

  assign stat_o.full      = (occ_q == CNT_W'(DEPTH));
  assign stat_o.empty     = (occ_q == '0);
  assign stat_o.dump_last = (dump_left_q == CNT_W'(1));
  assign out_item_o       = out_q;

endmodule

>>> rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// Controller: takes one item at a time, sequences store reads and hands
// results to the output channel.
// ----------------------------------------------------------------------------
module cfq_ctrl
  import cfq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  cfq_stat_t       stat_i,
  output cfq_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_DUMP_RD,
    S_OUT,
    S_DUMP_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q, out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{out_status: ST_EMPTY, default: '0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.out_last = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_PUSH: begin
              cmd_o.store      = !stat_i.full;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = stat_i.full ? ST_FULL : ST_PUSHED;
              state_d          = S_OUT;
            end
            MODE_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
                state_d          = S_OUT;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_POP_RD;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear      = 1'b1;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_CLEARED;
              state_d          = S_OUT;
            end
            MODE_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
                state_d          = S_OUT;
              end else begin
                cmd_o.rd_en     = 1'b1;
                cmd_o.dump_init = 1'b1;
                state_d         = S_DUMP_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP_RD: begin
        cmd_o.pop_adv    = 1'b1;
        cmd_o.out_load   = 1'b1;
        cmd_o.out_status = ST_POPPED;
        cmd_o.out_use_rd = 1'b1;
        cmd_o.out_last   = 1'b1;
        state_d          = S_OUT;
      end
      S_DUMP_RD: begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_status = ST_DUMPED;
        cmd_o.out_use_rd = 1'b1;
        cmd_o.out_last   = stat_i.dump_last;
        state_d          = S_DUMP_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            // Read the next entry while the walk steps on.
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_dump  = 1'b1;
            cmd_o.dump_adv = 1'b1;
            state_d        = S_DUMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_stall_q  <= (state_d != S_IDLE);
      out_valid_q <= (state_d == S_OUT) || (state_d == S_DUMP_OUT);
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/circular_fifo_with_clear_and_dump_core.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_clear_and_dump_core
// Ring-buffer queue of identifiers with push, pop, clear and dump.
// ----------------------------------------------------------------------------
// The block works on one item at a time. For a push, a clear, or a pop or
// dump on an empty queue, the item is taken and its single result is
// shown the next cycle and held until the output side takes it. A pop
// first makes a store read, since the entry store has one registered read
// port. A dump makes one store read per entry and shows each result, and
// issues the next read only once the output side has taken the prior one.
// The input stalls from the cycle after an item is taken until its last
// result has been taken. The occupancy count tells a full queue from an
// empty one, so a push to a full queue is rejected and never overwrites an
// entry. A clear resets only the pointers and the count; stored data is not erased.
module circular_fifo_with_clear_and_dump_core
  import cfq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cfq_cmd_t  cmd;
  cfq_stat_t stat;

  cfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (in_item_i.mode),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfq_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

endmodule

>>> tb/sv/circular_fifo_with_clear_and_dump_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_clear_and_dump_core_tb
// Self-checking bench for the identifier ring queue. A scoreboard mirrors
// the queue, predicts every result of each accepted item and checks the
// results in order. Both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
module circular_fifo_with_clear_and_dump_core_tb
  import cfq_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RAND_ITEMS   = 160;

  class fifo_scoreboard;
    logic [ID_BITS-1:0] slots [DEPTH];
    int unsigned head = 0;
    int unsigned tail = 0;
    int unsigned count = 0;
    int unsigned mismatches = 0;
    out_item_t expected_results [$];

    function void queue_result(status_e st, logic [FIELD_W-1:0] id, logic last);
      out_item_t res;
      res.status   = st;
      res.entry_id = id;
      res.last     = last;
      expected_results.push_back(res);
    endfunction

    function void predict_results(in_item_t item);
      logic [ID_BITS-1:0] id;
      int unsigned k;
      id = ID_BITS'(item.customer_id);
      case (mode_e'(item.mode))
        MODE_PUSH: begin
          if (count == DEPTH) begin
            queue_result(ST_FULL, '0, 1'b1);
          end else begin
            slots[tail] = id;
            tail = (tail + 1) % DEPTH;
            count++;
            queue_result(ST_PUSHED, '0, 1'b1);
          end
        end
        MODE_POP: begin
          if (count == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            queue_result(ST_POPPED, FIELD_W'(slots[head]), 1'b1);
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        MODE_CLEAR: begin
          head  = 0;
          tail  = 0;
          count = 0;
          queue_result(ST_CLEARED, '0, 1'b1);
        end
        default: begin
          if (count == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            // A dump walks head to tail and leaves the queue as it was.
            for (k = 0; k < count; k++) begin
              queue_result(ST_DUMPED, FIELD_W'(slots[(head + k) % DEPTH]),
                           (k + 1 == count));
            end
          end
        end
      endcase
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with nothing pending: status %0d id %h last %b",
                   got.status, got.entry_id, got.last);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.entry_id !== want.entry_id ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d id %h last %b, got status %0d id %h last %b",
                   want.status, want.entry_id, want.last,
                   got.status, got.entry_id, got.last);
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  fifo_scoreboard sb = new;

  int unsigned cycle_count = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  bit          hold_req    = 1'b0;

  circular_fifo_with_clear_and_dump_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[circular_fifo_with_clear_and_dump_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.compare_result(out_item);
    end
  end

  function automatic in_item_t make_item(mode_e m, logic [FIELD_W-1:0] id);
    in_item_t item;
    item.mode        = m;
    item.customer_id = id;
    return item;
  endfunction

  // Offers one item, waits for it to be taken, then maybe idles a burst.
  task automatic send_item(in_item_t item);
    in_valid <= 1'b1;
    in_item  <= item;
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
    sb.predict_results(item);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      in_item  <= make_item(mode_e'($urandom_range(0, 3)), FIELD_W'($urandom));
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  initial begin : output_stall_gen
    int unsigned burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Long hold-off: the queue backs up and the input side stalls.
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    int unsigned r;
    bit fill_bias;
    mode_e m;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    gap_pct   = 20;
    stall_pct = 15;

    // Empty queue first, then fill to the brim and overflow.
    send_item(make_item(MODE_DUMP, FIELD_W'($urandom)));
    send_item(make_item(MODE_POP, FIELD_W'($urandom)));
    send_item(make_item(MODE_PUSH, 16'h0000));
    send_item(make_item(MODE_PUSH, 16'hFFFF));
    send_item(make_item(MODE_PUSH, 16'h5555));
    send_item(make_item(MODE_PUSH, 16'hAAAA));
    send_item(make_item(MODE_PUSH, 16'h0001));
    send_item(make_item(MODE_PUSH, 16'h8000));
    send_item(make_item(MODE_PUSH, FIELD_W'($urandom)));
    send_item(make_item(MODE_PUSH, FIELD_W'($urandom)));
    send_item(make_item(MODE_PUSH, FIELD_W'($urandom)));
    send_item(make_item(MODE_DUMP, FIELD_W'($urandom)));
    // Pop two and refill so the full queue wraps around the ring.
    send_item(make_item(MODE_POP, FIELD_W'($urandom)));
    send_item(make_item(MODE_POP, FIELD_W'($urandom)));
    send_item(make_item(MODE_PUSH, 16'h1234));
    send_item(make_item(MODE_PUSH, 16'hEDCB));
    send_item(make_item(MODE_PUSH, FIELD_W'($urandom)));
    send_item(make_item(MODE_DUMP, FIELD_W'($urandom)));
    send_item(make_item(MODE_CLEAR, FIELD_W'($urandom)));
    send_item(make_item(MODE_DUMP, FIELD_W'($urandom)));
    send_item(make_item(MODE_POP, FIELD_W'($urandom)));
    send_item(make_item(MODE_PUSH, FIELD_W'($urandom)));
    send_item(make_item(MODE_DUMP, FIELD_W'($urandom)));

    // Phases of 20 items lean toward filling or draining the queue.
    fill_bias = 1'b1;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 20 == 0) begin
        fill_bias = ($urandom_range(0, 1) == 1);
        if (k >= RAND_ITEMS - 30) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          r = $urandom_range(0, 2);
          gap_pct   = (r == 0) ? 0 : ((r == 1) ? 30 : 60);
          r = $urandom_range(0, 2);
          stall_pct = (r == 0) ? 0 : ((r == 1) ? 10 : 25);
        end
      end
      if (k == 30) begin
        hold_req = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        m = MODE_CLEAR;
      end else if (r < 20) begin
        m = MODE_DUMP;
      end else if (fill_bias) begin
        m = (r < 88) ? MODE_PUSH : MODE_POP;
      end else begin
        m = (r < 45) ? MODE_PUSH : MODE_POP;
      end
      send_item(make_item(m, FIELD_W'($urandom)));
    end

    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("[circular_fifo_with_clear_and_dump_core] OK");
    end else begin
      $display("[circular_fifo_with_clear_and_dump_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cfq_pkg.sv
rtl/cfq_ram.sv
rtl/cfq_datapath.sv
rtl/cfq_ctrl.sv
rtl/circular_fifo_with_clear_and_dump_core.sv
tb/sv/circular_fifo_with_clear_and_dump_core_tb.sv
